/* sv/asv_pkg.sv */
// ----------------------------------------------------------------------------
// asv_pkg
// Shared types and constants for the address string validator.
// ----------------------------------------------------------------------------
package asv_pkg;

    localparam logic [2:0] STATUS_VALID    = 3'd0;
    localparam logic [2:0] STATUS_REQUIRED = 3'd1;
    localparam logic [2:0] STATUS_TOO_LONG = 3'd2;
    localparam logic [2:0] STATUS_BAD_CHAR = 3'd3;
    localparam logic [2:0] STATUS_NOT_ADDR = 3'd4;

    localparam int HOST_MAX  = 63;
    localparam int QUAD_MAX  = 255;
    localparam int QUAD_PART = 4;
    localparam int PARTS_CAP = 5;

    localparam logic [7:0] CHAR_HYPHEN = 8'h2d;
    localparam logic [7:0] CHAR_DOT    = 8'h2e;
    localparam logic [7:0] CHAR_COMMA  = 8'h2c;
    localparam logic [7:0] CHAR_CR     = 8'h0d;
    localparam logic [7:0] CHAR_LF     = 8'h0a;
    localparam logic [7:0] CHAR_QUOTE  = 8'h22;

    typedef struct packed {
        logic       has_char;
        logic [7:0] char_code;
        logic       last;
    } in_t;

    typedef struct packed {
        logic [2:0] status;
        logic       is_dotted_quad;
    } out_t;

    typedef struct packed {
        logic       special_seen;
        logic       quad_broken;
        logic [2:0] quad_parts;
        logic [1:0] quad_digits;
        logic [9:0] quad_value;
        logic       name_broken;
        logic [5:0] label_length;
        logic       prev_hyphen;
        logic       prev_dot;
    } scan_t;

endpackage

/* sv/address_string_validator_core.sv */
// ----------------------------------------------------------------------------
// address_string_validator_core
// Checks an address string, one character per transaction, for an IPv4
// dotted quad or a hostname and returns one status per string.
// ----------------------------------------------------------------------------
//  channel | direction | payload          | handshake
//  in      | input     | asv_pkg::in_t    | in_valid / in_ready
//  out     | output    | asv_pkg::out_t   | out_valid / out_ready
//
//  one character per cycle while no held result stalls a closing transaction;
//  a status reaches the result register after the closing transaction has
//  passed the input register; the scan state updates from the input register,
//  so strings may follow each other with no gap
//  reset clears the scan state and both valid flags
//  a held result stalls only a closing transaction; other characters go on
// ----------------------------------------------------------------------------
module address_string_validator_core #(
    parameter int MAX_LEN = 63
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  asv_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output asv_pkg::out_t out_data
);

    localparam int CNT_CAP = ((MAX_LEN > asv_pkg::HOST_MAX) ? MAX_LEN : asv_pkg::HOST_MAX) + 1;
    localparam int CNT_W   = $clog2(CNT_CAP + 1);

    logic             s1_valid_reg;
    asv_pkg::in_t     s1_data_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    asv_pkg::scan_t   scan_reg;
    asv_pkg::scan_t   scan_next;
    logic             out_valid_reg;
    asv_pkg::out_t    out_data_reg;
    asv_pkg::out_t    result;
    logic             emit;
    logic             out_free;
    logic             s1_go;

    asv_step #(
        .MAX_LEN (MAX_LEN),
        .CNT_W   (CNT_W)
    ) u_step (
        .item      (s1_data_reg),
        .cnt       (cnt_reg),
        .scan      (scan_reg),
        .cnt_next  (cnt_next),
        .scan_next (scan_next),
        .emit      (emit),
        .result    (result)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign s1_go    = s1_valid_reg && (!emit || out_free);
    assign in_ready = !s1_valid_reg || s1_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            cnt_reg       <= '0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (s1_go)
            begin
                cnt_reg  <= cnt_next;
                scan_reg <= scan_next;
            end
            if (s1_go && emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            s1_data_reg <= in_data;
        if (s1_go && emit)
            out_data_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* sv/asv_step.sv */
// ----------------------------------------------------------------------------
// asv_step
// Per-character scan update and end-of-string status decision.
// ----------------------------------------------------------------------------
module asv_step #(
    parameter int MAX_LEN = 63,
    parameter int CNT_W   = 7
) (
    input  asv_pkg::in_t   item,
    input  logic [CNT_W-1:0] cnt,
    input  asv_pkg::scan_t scan,
    output logic [CNT_W-1:0] cnt_next,
    output asv_pkg::scan_t scan_next,
    output logic           emit,
    output asv_pkg::out_t  result
);

    localparam int CNT_CAP = ((MAX_LEN > asv_pkg::HOST_MAX) ? MAX_LEN : asv_pkg::HOST_MAX) + 1;

    logic [CNT_W-1:0] cnt_mid;
    asv_pkg::scan_t   mid;
    asv_pkg::scan_t   closed;
    logic [7:0]       c;
    logic             is_digit;
    logic             is_letter;
    logic             quad_ok;
    logic             name_ok;

    assign c         = item.char_code;
    assign is_digit  = c inside {[8'h30:8'h39]};
    assign is_letter = (c inside {[8'h41:8'h5a]}) || (c inside {[8'h61:8'h7a]});

    // character intake
    always_comb
    begin
        cnt_mid = cnt;
        mid     = scan;
        if (item.has_char)
        begin
            if (cnt < CNT_W'(CNT_CAP))
                cnt_mid = cnt + CNT_W'(1);
            if (c == asv_pkg::CHAR_COMMA || c == asv_pkg::CHAR_CR ||
                c == asv_pkg::CHAR_LF || c == asv_pkg::CHAR_QUOTE)
                mid.special_seen = 1'b1;

            // dotted quad
            if (is_digit)
            begin
                if (scan.quad_digits == 2'd3)
                    mid.quad_broken = 1'b1;
                else
                begin
                    mid.quad_value  = 10'((scan.quad_value << 3) + (scan.quad_value << 1)
                                          + {6'd0, c[3:0]});
                    mid.quad_digits = scan.quad_digits + 2'd1;
                end
            end
            else if (c == asv_pkg::CHAR_DOT)
            begin
                if (scan.quad_digits == 2'd0 || scan.quad_value > 10'(asv_pkg::QUAD_MAX))
                    mid.quad_broken = 1'b1;
                if (scan.quad_parts < 3'(asv_pkg::PARTS_CAP))
                    mid.quad_parts = scan.quad_parts + 3'd1;
                mid.quad_digits = 2'd0;
                mid.quad_value  = 10'd0;
            end
            else
                mid.quad_broken = 1'b1;

            // hostname
            if (c == asv_pkg::CHAR_DOT)
            begin
                if (scan.label_length == 6'd0 || scan.prev_hyphen)
                    mid.name_broken = 1'b1;
                mid.label_length = 6'd0;
                mid.prev_dot     = 1'b1;
                mid.prev_hyphen  = 1'b0;
            end
            else if (is_letter || is_digit || c == asv_pkg::CHAR_HYPHEN)
            begin
                if (scan.label_length == 6'd0 && c == asv_pkg::CHAR_HYPHEN)
                    mid.name_broken = 1'b1;
                if (scan.label_length >= 6'(asv_pkg::HOST_MAX))
                    mid.name_broken = 1'b1;
                else
                    mid.label_length = scan.label_length + 6'd1;
                mid.prev_hyphen = (c == asv_pkg::CHAR_HYPHEN);
                mid.prev_dot    = 1'b0;
            end
            else
                mid.name_broken = 1'b1;
        end
    end

    // final part close and status
    always_comb
    begin
        closed = mid;
        if (mid.quad_digits == 2'd0 || mid.quad_value > 10'(asv_pkg::QUAD_MAX))
            closed.quad_broken = 1'b1;
        if (mid.quad_parts < 3'(asv_pkg::PARTS_CAP))
            closed.quad_parts = mid.quad_parts + 3'd1;

        quad_ok = !closed.quad_broken && closed.quad_parts == 3'(asv_pkg::QUAD_PART);
        name_ok = !mid.name_broken && cnt_mid != '0 &&
                  cnt_mid <= CNT_W'(asv_pkg::HOST_MAX) && !mid.prev_hyphen && !mid.prev_dot;

        if (cnt_mid == '0)
            result.status = asv_pkg::STATUS_REQUIRED;
        else if (cnt_mid > CNT_W'(MAX_LEN))
            result.status = asv_pkg::STATUS_TOO_LONG;
        else if (mid.special_seen)
            result.status = asv_pkg::STATUS_BAD_CHAR;
        else if (!quad_ok && !name_ok)
            result.status = asv_pkg::STATUS_NOT_ADDR;
        else
            result.status = asv_pkg::STATUS_VALID;
        result.is_dotted_quad = quad_ok;
    end

    assign emit      = !item.has_char || item.last;
    assign cnt_next  = emit ? '0 : cnt_mid;
    assign scan_next = emit ? '0 : mid;

endmodule

/* sv/asv_checker.sv */
// ----------------------------------------------------------------------------
// asv_checker
// Port-level checks for the address string validator.
// ----------------------------------------------------------------------------
module asv_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input asv_pkg::in_t  in_data,
    input logic          out_valid,
    input logic          out_ready,
    input asv_pkg::out_t out_data
);

    // stalled input transaction holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("input changed while stalled");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.status == asv_pkg::STATUS_VALID ||
                       out_data.status == asv_pkg::STATUS_REQUIRED ||
                       out_data.status == asv_pkg::STATUS_TOO_LONG ||
                       out_data.status == asv_pkg::STATUS_BAD_CHAR ||
                       out_data.status == asv_pkg::STATUS_NOT_ADDR))
        else $error("status code out of range");

    // a dotted quad is never empty nor rejected as an address
    a_quad_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.is_dotted_quad |->
            out_data.status != asv_pkg::STATUS_REQUIRED &&
            out_data.status != asv_pkg::STATUS_NOT_ADDR)
        else $error("dotted quad with inconsistent status");

    // input side only waits on a full result register
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

endmodule

bind address_string_validator_core asv_checker u_asv_checker (.*);
